// ===== rtl/core/ssdp_request_parser_defines.svh =====
`ifndef SSDP_REQUEST_PARSER_DEFINES_SVH
`define SSDP_REQUEST_PARSER_DEFINES_SVH

// same-cycle implication, reset masked
`define SSDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define SSDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssdp_pkg.sv =====
`default_nettype none

package ssdp_pkg;

    localparam int TEXT_BYTES   = 64;
    localparam int METHOD_BYTES = 10;
    localparam int URI_BYTES    = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_RET   = 8'h0d;

    // patterns padded to eight characters, first character in the top byte
    localparam logic [63:0] PAT_MSEARCH = "M-SEARCH";
    localparam logic [63:0] PAT_NOTIFY  = {"NOTIFY", 16'h0000};
    localparam logic [63:0] PAT_STAR    = {"*", 56'h0};
    localparam logic [63:0] PAT_MA      = {"MA", 48'h0};
    localparam logic [63:0] PAT_ST      = {"ST", 48'h0};
    localparam logic [63:0] PAT_MX      = {"MX", 48'h0};

    localparam logic [3:0] LEN_MSEARCH = 4'd8;
    localparam logic [3:0] LEN_NOTIFY  = 4'd6;
    localparam logic [3:0] LEN_STAR    = 4'd1;
    localparam logic [3:0] LEN_PAIR    = 4'd2;

    localparam int FL_MSEARCH = 0;
    localparam int FL_NOTIFY  = 1;
    localparam int FL_STAR    = 2;
    localparam int FL_MA      = 3;
    localparam int FL_ST      = 4;
    localparam int FL_MX      = 5;
    localparam logic [5:0] FL_ALL = 6'h3f;

    localparam logic [1:0] MC_NONE    = 2'd0;
    localparam logic [1:0] MC_MSEARCH = 2'd1;
    localparam logic [1:0] MC_NOTIFY  = 2'd2;

    localparam logic [19:0] MAG_MAX = 20'd65535;

    typedef enum logic [5:0] {
        PH_METHOD = 6'b000001,
        PH_URI    = 6'b000010,
        PH_PROTO  = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_VALUE  = 6'b010000,
        PH_ABORT  = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        HK_NONE = 2'd0,
        HK_MAN  = 2'd1,
        HK_ST   = 2'd2,
        HK_MX   = 2'd3
    } t_hdr;

    typedef enum logic [1:0] {
        AT_SKIP = 2'd0,
        AT_NUM  = 2'd1,
        AT_STOP = 2'd2
    } t_atoi;

    typedef struct packed {
        logic [5:0]  flags;
        t_atoi       aph;
        logic        neg;
        logic [15:0] mag;
    } t_text;

    localparam t_text TEXT_RESET = '{flags: FL_ALL, aph: AT_SKIP, neg: 1'b0, mag: 16'd0};

    // prefix step against one padded pattern
    function automatic logic f_pfx(input logic ok, input logic in_range,
                                   input logic [2:0] idx, input logic [63:0] pat,
                                   input logic [3:0] plen, input logic [7:0] c);
        logic [7:0] ch;
        ch = pat[{~idx, 3'b000} +: 8];
        return ok && in_range && ({1'b0, idx} < plen) && (ch == c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssdp_request_parser.sv =====
// SSDP request parser
// Byte stream in on the s_axis channel: tdata carries one datagram byte, tlast
// marks the final byte of the datagram. One result per datagram leaves on the
// m_axis channel when the final byte has been processed; no other byte gives
// a result. Result fields in tdata: respond, method_seen, mx_seconds, aborted.
// A byte is taken into an input register and processed from there by the
// parser logic; if it was the last one, its verdict lands in the output
// register, from which the result is offered. Throughput is one byte per
// clock while no result waits on m_axis tready, set by the combinational
// parser step between input register and state registers.
// If the result waits on m_axis tready, the byte held in the input register
// waits too and s_axis tready drops after one more byte; flow resumes at full
// rate once the result is taken.
// Synchronous active-low reset returns the parser to the method phase with
// all match state cleared and empties both the input and output registers.
// After each final byte the parser returns to the same reset state.
`default_nettype none

`include "ssdp_request_parser_defines.svh"

module ssdp_request_parser #(
    parameter int TEXT_BYTES   = ssdp_pkg::TEXT_BYTES,
    parameter int METHOD_BYTES = ssdp_pkg::METHOD_BYTES,
    parameter int URI_BYTES    = ssdp_pkg::URI_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // rx_byte
    input  wire logic        i_s_axis_tlast,  // last_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata   // respond, method_seen[2:1], mx_seconds[18:3],
                                              // aborted[19], zero fill
);

    localparam int MAX_A = (TEXT_BYTES > METHOD_BYTES) ? TEXT_BYTES : METHOD_BYTES;
    localparam int MAX_B = (MAX_A > URI_BYTES) ? MAX_A : URI_BYTES;
    localparam int LEN_W = $clog2(MAX_B);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_last;

    ssdp_pkg::t_phase     r_phase, n_phase;
    logic [2:0]           r_lbc, n_lbc;
    logic [LEN_W-1:0]     r_wpos, n_wpos;
    logic [LEN_W-1:0]     r_len, n_len;
    ssdp_pkg::t_hdr       r_hk, n_hk;
    logic [1:0]           r_method, n_method;
    logic                 r_pending, n_pending;
    ssdp_pkg::t_text      r_text, n_text;
    logic [15:0]          r_mx, n_mx;

    logic                 r_out_valid;
    logic                 r_out_respond;
    logic [1:0]           r_out_method;
    logic [15:0]          r_out_mx;
    logic                 r_out_aborted;

    ssdp_pkg::t_text      tu_text;
    logic [LEN_W-1:0]     tu_len;
    logic                 adv;
    logic                 brk;
    logic                 put;
    logic                 eq_ms, eq_nt, eq_star, eq_st, eq_mx;
    logic [1:0]           mc_new;
    logic                 res_respond;
    logic [1:0]           res_method;
    logic [15:0]          res_mx;
    logic                 res_aborted;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'h0, r_out_aborted, r_out_mx, r_out_method, r_out_respond};

    ssdp_text_unit #(
        .LEN_W (LEN_W)
    ) u_text (
        .i_byte (r_in_byte),
        .i_pos  (r_wpos),
        .i_len  (r_len),
        .i_text (r_text),
        .o_text (tu_text),
        .o_len  (tu_len)
    );

    always_comb begin
        brk     = (r_in_byte == ssdp_pkg::CH_CR) || (r_in_byte == ssdp_pkg::CH_LF);
        eq_ms   = r_text.flags[ssdp_pkg::FL_MSEARCH] && (r_len == LEN_W'(ssdp_pkg::LEN_MSEARCH));
        eq_nt   = r_text.flags[ssdp_pkg::FL_NOTIFY] && (r_len == LEN_W'(ssdp_pkg::LEN_NOTIFY));
        eq_star = r_text.flags[ssdp_pkg::FL_STAR] && (r_len == LEN_W'(ssdp_pkg::LEN_STAR));
        eq_st   = r_text.flags[ssdp_pkg::FL_ST] && (r_len == LEN_W'(ssdp_pkg::LEN_PAIR));
        eq_mx   = r_text.flags[ssdp_pkg::FL_MX] && (r_len == LEN_W'(ssdp_pkg::LEN_PAIR));
        mc_new  = eq_ms ? ssdp_pkg::MC_MSEARCH : (eq_nt ? ssdp_pkg::MC_NOTIFY : r_method);

        n_phase   = r_phase;
        n_wpos    = r_wpos;
        n_len     = r_len;
        n_hk      = r_hk;
        n_method  = r_method;
        n_pending = r_pending;
        n_text    = r_text;
        n_mx      = r_mx;
        put       = 1'b0;

        if (brk) begin
            n_lbc = (r_lbc == 3'd7) ? r_lbc : r_lbc + 3'd1;
        end else begin
            n_lbc = 3'd0;
        end

        case (r_phase)
            ssdp_pkg::PH_METHOD: begin
                if (r_in_byte == ssdp_pkg::CH_SPACE) begin
                    n_method = mc_new;
                    n_phase  = (mc_new != ssdp_pkg::MC_NONE) ? ssdp_pkg::PH_URI
                                                             : ssdp_pkg::PH_ABORT;
                    n_wpos   = '0;
                end else if (r_wpos < LEN_W'(METHOD_BYTES - 1)) begin
                    put = 1'b1;
                end
            end
            ssdp_pkg::PH_URI: begin
                if (r_in_byte == ssdp_pkg::CH_SPACE) begin
                    n_phase = eq_star ? ssdp_pkg::PH_PROTO : ssdp_pkg::PH_ABORT;
                    n_wpos  = '0;
                end else if (r_wpos < LEN_W'(URI_BYTES - 1)) begin
                    put = 1'b1;
                end
            end
            ssdp_pkg::PH_PROTO: begin
                if (n_lbc == 3'd2) begin
                    n_phase = ssdp_pkg::PH_KEY;
                    n_wpos  = '0;
                end
            end
            ssdp_pkg::PH_KEY: begin
                if (n_lbc == 3'd4) begin
                    n_pending = 1'b1;
                end else if (r_in_byte == ssdp_pkg::CH_SPACE) begin
                    n_wpos  = '0;
                    n_phase = ssdp_pkg::PH_VALUE;
                end else if (!brk && (r_in_byte != ssdp_pkg::CH_COLON)
                             && (r_wpos < LEN_W'(TEXT_BYTES - 1))) begin
                    put = 1'b1;
                end
            end
            ssdp_pkg::PH_VALUE: begin
                if (n_lbc == 3'd2) begin
                    if (r_hk == ssdp_pkg::HK_MX) begin
                        n_mx = r_text.neg ? 16'd0 : r_text.mag;
                    end
                    n_phase = ssdp_pkg::PH_KEY;
                    n_hk    = ssdp_pkg::HK_NONE;
                    n_wpos  = '0;
                end else if (!brk) begin
                    if (r_hk == ssdp_pkg::HK_NONE) begin
                        if ((r_len >= LEN_W'(ssdp_pkg::LEN_PAIR))
                            && r_text.flags[ssdp_pkg::FL_MA]) begin
                            n_hk = ssdp_pkg::HK_MAN;
                        end else if (eq_st) begin
                            n_hk = ssdp_pkg::HK_ST;
                        end else if (eq_mx) begin
                            n_hk = ssdp_pkg::HK_MX;
                        end
                    end
                    if (r_wpos < LEN_W'(TEXT_BYTES - 1)) begin
                        put = 1'b1;
                    end
                end
            end
            ssdp_pkg::PH_ABORT: begin
                n_pending = 1'b0;
                n_mx      = 16'd0;
            end
            default: begin
            end
        endcase

        if (put) begin
            n_wpos = r_wpos + LEN_W'(1);
            n_text = tu_text;
            n_len  = tu_len;
        end

        res_respond = n_pending;
        res_method  = n_method;
        res_mx      = n_mx;
        res_aborted = (n_phase == ssdp_pkg::PH_ABORT);

        // datagram end: back to the reset state
        if (r_in_last) begin
            n_phase   = ssdp_pkg::PH_METHOD;
            n_lbc     = 3'd0;
            n_wpos    = '0;
            n_len     = '0;
            n_hk      = ssdp_pkg::HK_NONE;
            n_method  = ssdp_pkg::MC_NONE;
            n_pending = 1'b0;
            n_text    = ssdp_pkg::TEXT_RESET;
            n_mx      = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ssdp_pkg::PH_METHOD;
            r_lbc     <= 3'd0;
            r_wpos    <= '0;
            r_len     <= '0;
            r_hk      <= ssdp_pkg::HK_NONE;
            r_method  <= ssdp_pkg::MC_NONE;
            r_pending <= 1'b0;
            r_text    <= ssdp_pkg::TEXT_RESET;
            r_mx      <= 16'd0;
        end else if (adv) begin
            r_phase   <= n_phase;
            r_lbc     <= n_lbc;
            r_wpos    <= n_wpos;
            r_len     <= n_len;
            r_hk      <= n_hk;
            r_method  <= n_method;
            r_pending <= n_pending;
            r_text    <= n_text;
            r_mx      <= n_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_in_last) begin
            r_out_respond <= res_respond;
            r_out_method  <= res_method;
            r_out_mx      <= res_mx;
            r_out_aborted <= res_aborted;
        end
    end

    `SSDP_ASSERT_NEXT(a_last_resets, i_clk, i_rst_n, adv && r_in_last,
        (r_phase == ssdp_pkg::PH_METHOD) && (r_wpos == '0) && !r_pending, "no reset after last")
    `SSDP_ASSERT_NOW(a_wpos_bound, i_clk, i_rst_n, 1'b1,
        r_wpos <= LEN_W'(MAX_B - 1), "write position out of range")
    `SSDP_ASSERT_NOW(a_abort_clean, i_clk, i_rst_n, r_out_valid && r_out_aborted,
        !r_out_respond && (r_out_mx == 16'd0), "aborted result carries data")
    `SSDP_ASSERT_NOW(a_method_known, i_clk, i_rst_n,
        (r_phase == ssdp_pkg::PH_URI) || (r_phase == ssdp_pkg::PH_PROTO)
        || (r_phase == ssdp_pkg::PH_KEY) || (r_phase == ssdp_pkg::PH_VALUE),
        r_method != ssdp_pkg::MC_NONE, "past method phase without method")

endmodule

`default_nettype wire

// ===== rtl/core/ssdp_text_unit.sv =====
`default_nettype none

module ssdp_text_unit #(
    parameter int LEN_W = 6
) (
    input  wire logic [7:0]       i_byte,
    input  wire logic [LEN_W-1:0] i_pos,
    input  wire logic [LEN_W-1:0] i_len,
    input  wire ssdp_pkg::t_text  i_text,
    output ssdp_pkg::t_text       o_text,
    output logic      [LEN_W-1:0] o_len
);

    ssdp_pkg::t_text  base;
    logic [LEN_W-1:0] base_len;
    logic             in_range;
    logic [2:0]       idx;
    logic             digit;
    logic             blank;
    logic [19:0]      prod;
    logic [7:0]       dval;

    always_comb begin
        base     = (i_pos == '0) ? ssdp_pkg::TEXT_RESET : i_text;
        base_len = (i_pos == '0) ? '0 : i_len;
        in_range = (i_pos >> 3) == '0;
        idx      = i_pos[2:0];
        digit    = (i_byte >= ssdp_pkg::CH_ZERO) && (i_byte <= ssdp_pkg::CH_NINE);
        blank    = (i_byte == ssdp_pkg::CH_SPACE)
                || ((i_byte >= ssdp_pkg::CH_TAB) && (i_byte <= ssdp_pkg::CH_RET));
        dval     = i_byte - ssdp_pkg::CH_ZERO;
        prod     = 20'({i_text.mag, 3'b000}) + 20'({i_text.mag, 1'b0}) + 20'(dval[3:0]);
        o_text   = i_text;
        o_len    = i_len;
        if ((i_pos == '0) || (i_len == i_pos)) begin
            o_text = base;
            o_len  = base_len;
            if (i_byte == 8'h00) begin
                o_len = i_pos;
            end else begin
                o_text.flags[ssdp_pkg::FL_MSEARCH] = ssdp_pkg::f_pfx(
                    base.flags[ssdp_pkg::FL_MSEARCH], in_range, idx,
                    ssdp_pkg::PAT_MSEARCH, ssdp_pkg::LEN_MSEARCH, i_byte);
                o_text.flags[ssdp_pkg::FL_NOTIFY] = ssdp_pkg::f_pfx(
                    base.flags[ssdp_pkg::FL_NOTIFY], in_range, idx,
                    ssdp_pkg::PAT_NOTIFY, ssdp_pkg::LEN_NOTIFY, i_byte);
                o_text.flags[ssdp_pkg::FL_STAR] = ssdp_pkg::f_pfx(
                    base.flags[ssdp_pkg::FL_STAR], in_range, idx,
                    ssdp_pkg::PAT_STAR, ssdp_pkg::LEN_STAR, i_byte);
                if (in_range && (idx < 3'd2)) begin
                    o_text.flags[ssdp_pkg::FL_MA] = ssdp_pkg::f_pfx(
                        base.flags[ssdp_pkg::FL_MA], in_range, idx,
                        ssdp_pkg::PAT_MA, ssdp_pkg::LEN_PAIR, i_byte);
                end
                o_text.flags[ssdp_pkg::FL_ST] = ssdp_pkg::f_pfx(
                    base.flags[ssdp_pkg::FL_ST], in_range, idx,
                    ssdp_pkg::PAT_ST, ssdp_pkg::LEN_PAIR, i_byte);
                o_text.flags[ssdp_pkg::FL_MX] = ssdp_pkg::f_pfx(
                    base.flags[ssdp_pkg::FL_MX], in_range, idx,
                    ssdp_pkg::PAT_MX, ssdp_pkg::LEN_PAIR, i_byte);

                // decimal conversion, leading blanks skipped
                case (base.aph)
                    ssdp_pkg::AT_SKIP: begin
                        if (!blank) begin
                            if (i_byte == ssdp_pkg::CH_PLUS) begin
                                o_text.aph = ssdp_pkg::AT_NUM;
                            end else if (i_byte == ssdp_pkg::CH_MINUS) begin
                                o_text.aph = ssdp_pkg::AT_NUM;
                                o_text.neg = 1'b1;
                            end else if (digit) begin
                                o_text.aph = ssdp_pkg::AT_NUM;
                                o_text.mag = 16'(dval[3:0]);
                            end else begin
                                o_text.aph = ssdp_pkg::AT_STOP;
                            end
                        end
                    end
                    ssdp_pkg::AT_NUM: begin
                        if (digit) begin
                            o_text.mag = (prod > ssdp_pkg::MAG_MAX) ? 16'hffff : prod[15:0];
                        end else begin
                            o_text.aph = ssdp_pkg::AT_STOP;
                        end
                    end
                    default: begin
                    end
                endcase
                o_len = i_pos + LEN_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/ssdp_request_parser_tb.sv =====
`timescale 1ns / 1ps

module ssdp_request_parser_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MIN_BYTES   = 1500;
    localparam int MIN_FRAMES  = 26;
    localparam int HOLD_CYCLES = 400;
    localparam logic [7:0] NUL_MARK = 8'h7f;

    typedef struct packed {
        logic        respond;
        logic [1:0]  method;
        logic [15:0] mx;
        logic        aborted;
    } t_verdict;

    typedef struct packed {
        logic     known;
        t_verdict want;
    } t_hint;

    typedef struct {
        string    text;
        logic     known;
        t_verdict want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // rx_byte
    logic        i_s_axis_tlast;   // last_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // respond, method_seen, mx_seconds, aborted, zero fill

    // parser state as predicted
    ssdp_pkg::t_phase ps_phase;
    logic [2:0]       ps_breaks;
    int               ps_wpos;
    ssdp_pkg::t_hdr   ps_hdr;
    logic [1:0]       ps_method;
    logic             ps_pending;
    logic [5:0]       ps_flags;
    ssdp_pkg::t_atoi  ps_aph;
    logic             ps_neg;
    logic [15:0]      ps_mag;
    int               ps_tlen;
    logic [15:0]      ps_mx;

    t_verdict    pending_verdicts [$];
    t_hint       frame_hints [$];
    logic [7:0]  frame [$];
    int          errors = 0;
    int          cycle_count = 0;
    int          hold_len = 0;
    bit          quiet = 1'b0;

    // DEL in a table string stands for a zero byte
    t_row dir_rows [15] = '{
        '{"X", 1'b1, '{1'b0, ssdp_pkg::MC_NONE, 16'd0, 1'b0}},
        '{"GET * x", 1'b1, '{1'b0, ssdp_pkg::MC_NONE, 16'd0, 1'b1}},
        '{"M-SEARCH / HTTP/1.1\015\012\015\012", 1'b1,
          '{1'b0, ssdp_pkg::MC_MSEARCH, 16'd0, 1'b1}},
        '{{"M-SEARCH * HTTP/1.1\015\012HOST: h\015\012",
           "MAN: \"d\"\015\012MX: 5\015\012ST: a\015\012\015\012"},
          1'b1, '{1'b1, ssdp_pkg::MC_MSEARCH, 16'd5, 1'b0}},
        '{"NOTIFY * HTTP/1.1\015\012NT: upnp\015\012NTS: alive\015\012\015\012",
          1'b1, '{1'b1, ssdp_pkg::MC_NOTIFY, 16'd0, 1'b0}},
        '{"M-SEARCH * HTTP/1.1\015\012MX: 99999\015\012\015\012",
          1'b1, '{1'b1, ssdp_pkg::MC_MSEARCH, 16'd65535, 1'b0}},
        '{"M-SEARCH * HTTP/1.1\015\012MX: -3\015\012\015\012",
          1'b1, '{1'b1, ssdp_pkg::MC_MSEARCH, 16'd0, 1'b0}},
        '{"M-SEARCH *abc HTTP/1.1\015\012MX:  +12x\015\012\015\012", 1'b0, '0},
        '{"M-SEARCH * P\015\012MX:\015\012 8\015\012\015\012", 1'b0, '0},
        '{"M-SEARCH * P\015\012M\177X: 4\015\012\015\012", 1'b0, '0},
        '{"M-SEARCHXYZ * P\015\012\015\012", 1'b0, '0},
        '{"NOTIFY * P\015\012\015\012\015\012\015\012\015\012\377", 1'b0, '0},
        '{"M-SEARCH * HTTP/1.1\015\012ST: ssdp:all", 1'b0, '0},
        '{"\377\177 *", 1'b0, '0},
        '{"M-SEARCH * P\012\012MAN: x\012\012MX: 0012\012\012\012\012", 1'b0, '0}
    };

    ssdp_request_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_parser();
        ps_phase   = ssdp_pkg::PH_METHOD;
        ps_breaks  = '0;
        ps_wpos    = 0;
        ps_hdr     = ssdp_pkg::HK_NONE;
        ps_method  = ssdp_pkg::MC_NONE;
        ps_pending = 1'b0;
        ps_flags   = ssdp_pkg::FL_ALL;
        ps_aph     = ssdp_pkg::AT_SKIP;
        ps_neg     = 1'b0;
        ps_mag     = '0;
        ps_tlen    = 0;
        ps_mx      = '0;
    endfunction

    function automatic void match_char(int idx, logic [63:0] pat, int plen, int p,
                                       logic [7:0] c);
        if (p >= plen)
            ps_flags[idx] = 1'b0;
        else
            ps_flags[idx] = ps_flags[idx] && (pat[(7 - p) * 8 +: 8] == c);
    endfunction

    function automatic void text_put(logic [7:0] c);
        int   p;
        int   m;
        logic digit;
        p = ps_wpos;
        ps_wpos = ps_wpos + 1;
        if (p != 0 && ps_tlen != p)
            return;
        if (p == 0) begin
            ps_flags = ssdp_pkg::FL_ALL;
            ps_aph   = ssdp_pkg::AT_SKIP;
            ps_neg   = 1'b0;
            ps_mag   = '0;
            ps_tlen  = 0;
        end
        if (c == 8'h00) begin
            ps_tlen = p;
            return;
        end
        match_char(ssdp_pkg::FL_MSEARCH, ssdp_pkg::PAT_MSEARCH, ssdp_pkg::LEN_MSEARCH, p, c);
        match_char(ssdp_pkg::FL_NOTIFY, ssdp_pkg::PAT_NOTIFY, ssdp_pkg::LEN_NOTIFY, p, c);
        match_char(ssdp_pkg::FL_STAR, ssdp_pkg::PAT_STAR, ssdp_pkg::LEN_STAR, p, c);
        if (p < 2)
            match_char(ssdp_pkg::FL_MA, ssdp_pkg::PAT_MA, ssdp_pkg::LEN_PAIR, p, c);
        match_char(ssdp_pkg::FL_ST, ssdp_pkg::PAT_ST, ssdp_pkg::LEN_PAIR, p, c);
        match_char(ssdp_pkg::FL_MX, ssdp_pkg::PAT_MX, ssdp_pkg::LEN_PAIR, p, c);
        // decimal read, leading blanks skipped
        digit = c >= ssdp_pkg::CH_ZERO && c <= ssdp_pkg::CH_NINE;
        if (ps_aph == ssdp_pkg::AT_SKIP) begin
            if (!(c == ssdp_pkg::CH_SPACE
                  || (c >= ssdp_pkg::CH_TAB && c <= ssdp_pkg::CH_RET))) begin
                ps_aph = (c == ssdp_pkg::CH_PLUS || c == ssdp_pkg::CH_MINUS || digit)
                       ? ssdp_pkg::AT_NUM : ssdp_pkg::AT_STOP;
                if (c == ssdp_pkg::CH_MINUS)
                    ps_neg = 1'b1;
                if (digit)
                    ps_mag = 16'(c - ssdp_pkg::CH_ZERO);
            end
        end else if (ps_aph == ssdp_pkg::AT_NUM) begin
            if (digit) begin
                m = int'(ps_mag) * 10 + int'(c - ssdp_pkg::CH_ZERO);
                ps_mag = m > 65535 ? 16'hffff : 16'(m);
            end else begin
                ps_aph = ssdp_pkg::AT_STOP;
            end
        end
        ps_tlen = p + 1;
    endfunction

    function automatic bit predict_verdict(input logic [7:0] c, input logic last,
                                           output t_verdict v);
        logic brk;
        brk = c == ssdp_pkg::CH_CR || c == ssdp_pkg::CH_LF;
        if (brk) begin
            if (ps_breaks != 3'd7)
                ps_breaks = ps_breaks + 3'd1;
        end else begin
            ps_breaks = '0;
        end
        case (ps_phase)
            ssdp_pkg::PH_METHOD: begin
                if (c == ssdp_pkg::CH_SPACE) begin
                    if (ps_flags[ssdp_pkg::FL_MSEARCH] && ps_tlen == ssdp_pkg::LEN_MSEARCH)
                        ps_method = ssdp_pkg::MC_MSEARCH;
                    else if (ps_flags[ssdp_pkg::FL_NOTIFY] && ps_tlen == ssdp_pkg::LEN_NOTIFY)
                        ps_method = ssdp_pkg::MC_NOTIFY;
                    ps_phase = ps_method != ssdp_pkg::MC_NONE ? ssdp_pkg::PH_URI
                                                              : ssdp_pkg::PH_ABORT;
                    ps_wpos = 0;
                end else if (ps_wpos < ssdp_pkg::METHOD_BYTES - 1) begin
                    text_put(c);
                end
            end
            ssdp_pkg::PH_URI: begin
                if (c == ssdp_pkg::CH_SPACE) begin
                    ps_phase = (ps_flags[ssdp_pkg::FL_STAR] && ps_tlen == ssdp_pkg::LEN_STAR)
                             ? ssdp_pkg::PH_PROTO : ssdp_pkg::PH_ABORT;
                    ps_wpos = 0;
                end else if (ps_wpos < ssdp_pkg::URI_BYTES - 1) begin
                    text_put(c);
                end
            end
            ssdp_pkg::PH_PROTO: begin
                if (ps_breaks == 3'd2) begin
                    ps_phase = ssdp_pkg::PH_KEY;
                    ps_wpos = 0;
                end
            end
            ssdp_pkg::PH_KEY: begin
                if (ps_breaks == 3'd4) begin
                    ps_pending = 1'b1;
                end else if (c == ssdp_pkg::CH_SPACE) begin
                    ps_wpos = 0;
                    ps_phase = ssdp_pkg::PH_VALUE;
                end else if (!brk && c != ssdp_pkg::CH_COLON
                             && ps_wpos < ssdp_pkg::TEXT_BYTES - 1) begin
                    text_put(c);
                end
            end
            ssdp_pkg::PH_VALUE: begin
                if (ps_breaks == 3'd2) begin
                    if (ps_hdr == ssdp_pkg::HK_MX)
                        ps_mx = ps_neg ? 16'd0 : ps_mag;
                    ps_phase = ssdp_pkg::PH_KEY;
                    ps_hdr = ssdp_pkg::HK_NONE;
                    ps_wpos = 0;
                end else if (!brk) begin
                    if (ps_hdr == ssdp_pkg::HK_NONE) begin
                        if (ps_tlen >= 2 && ps_flags[ssdp_pkg::FL_MA])
                            ps_hdr = ssdp_pkg::HK_MAN;
                        else if (ps_flags[ssdp_pkg::FL_ST] && ps_tlen == ssdp_pkg::LEN_PAIR)
                            ps_hdr = ssdp_pkg::HK_ST;
                        else if (ps_flags[ssdp_pkg::FL_MX] && ps_tlen == ssdp_pkg::LEN_PAIR)
                            ps_hdr = ssdp_pkg::HK_MX;
                    end
                    if (ps_wpos < ssdp_pkg::TEXT_BYTES - 1)
                        text_put(c);
                end
            end
            ssdp_pkg::PH_ABORT: begin
                ps_pending = 1'b0;
                ps_mx = '0;
            end
            default: ;
        endcase
        v = '{ps_pending, ps_method, ps_mx, ps_phase == ssdp_pkg::PH_ABORT};
        if (!last)
            return 1'b0;
        clear_parser();
        return 1'b1;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i] == NUL_MARK ? 8'h00 : 8'(s[i]));
    endfunction

    function automatic void add_chars(int n, int lo, int hi);
        repeat (n) frame.push_back(8'($urandom_range(hi, lo)));
    endfunction

    function automatic void add_eol();
        case ($urandom_range(9, 0))
            8: add_text("\012\012");
            9: add_text("\015");
            default: add_text("\015\012");
        endcase
    endfunction

    // mostly well-formed requests with random content, the rest noise
    function automatic void build_request();
        int kpick;
        if ($urandom_range(99, 0) < 10) begin
            add_chars($urandom_range(24, 1), 0, 255);
            return;
        end
        case ($urandom_range(9, 0))
            0, 1, 2, 3: add_text("M-SEARCH");
            4, 5, 6: add_text("NOTIFY");
            7: add_chars($urandom_range(12, 1), 33, 126);
            8: begin
                if ($urandom_range(1, 0) != 0)
                    add_text("M-SEARCHX");
                else
                    add_text("NOTIF");
            end
            default: ;
        endcase
        add_text(" ");
        case ($urandom_range(9, 0))
            8: begin
                add_text("*");
                add_chars($urandom_range(3, 1), 33, 126);
            end
            9: add_chars($urandom_range(3, 1), 33, 126);
            default: add_text("*");
        endcase
        add_text(" HTTP/1.1");
        add_eol();
        repeat ($urandom_range(5, 0)) begin
            kpick = $urandom_range(9, 0);
            case (kpick)
                0: add_text("MAN");
                1: add_text("ST");
                2, 3: add_text("MX");
                4: add_text("HOST");
                5: add_text("MA");
                6: add_text("M");
                7: add_text("S");
                8: add_chars($urandom_range(70, 0), 33, 126);
                default: ;
            endcase
            if ($urandom_range(9, 0) != 0)
                add_text(":");
            add_chars($urandom_range(3, 0), 32, 32);
            if (kpick == 2 || kpick == 3) begin
                case ($urandom_range(3, 0))
                    0: add_text("-");
                    1: add_text("+");
                    default: ;
                endcase
                add_chars($urandom_range(7, 0), 48, 57);
                if ($urandom_range(3, 0) == 0)
                    add_chars($urandom_range(3, 1), 33, 126);
            end else begin
                add_chars($urandom_range(19, 0) == 0 ? 70 : $urandom_range(20, 0), 32, 126);
            end
            add_eol();
        end
        if ($urandom_range(4, 0) != 0)
            add_eol();
        if ($urandom_range(9, 0) == 0)
            frame[$urandom_range(frame.size() - 1, 0)] = 8'($urandom_range(255, 0));
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(14, 0);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic known, input t_verdict want);
        frame_hints.push_back('{known, want});
        foreach (frame[i]) put_byte(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    task automatic drain_verdicts();
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_verdict res;
        t_hint    hint;
        t_verdict want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (predict_verdict(i_s_axis_tdata, i_s_axis_tlast, res)) begin
                    hint = frame_hints.pop_front();
                    pending_verdicts.push_back(hint.known ? hint.want : res);
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t unexpected verdict, expected none actual %h",
                             $time, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("respond", 16'(want.respond), 16'(o_m_axis_tdata[0]));
                    check_field("method_seen", 16'(want.method), 16'(o_m_axis_tdata[2:1]));
                    check_field("mx_seconds", want.mx, o_m_axis_tdata[18:3]);
                    check_field("aborted", 16'(want.aborted), 16'(o_m_axis_tdata[19]));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side
    initial begin
        int stall;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_len > 0) begin
                stall = hold_len;
                hold_len = 0;
            end else begin
                stall = quiet ? 0 : $urandom_range(14, 0);
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid && hold_len == 0);
        end
    end

    // byte side
    initial begin
        int sent;
        int frames;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tlast  <= 1'b0;
        clear_parser();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sent = 0;
        frames = 0;
        foreach (dir_rows[r]) begin
            add_text(dir_rows[r].text);
            sent += frame.size();
            send_frame(dir_rows[r].known, dir_rows[r].want);
        end
        while (sent < MIN_BYTES || frames < MIN_FRAMES) begin
            quiet = $urandom_range(4, 0) == 0;
            if (frames == 8) begin
                // long receiver hold with back-to-back short datagrams
                hold_len = HOLD_CYCLES;
                quiet = 1'b1;
                repeat (12) begin
                    add_text("X");
                    send_frame(1'b0, '0);
                end
                sent += 12;
                frames += 12;
                quiet = 1'b0;
            end
            if (frames % 25 == 24) begin
                i_s_axis_tvalid <= 1'b0;
                drain_verdicts();
            end
            build_request();
            sent += frame.size();
            send_frame(1'b0, '0);
            frames++;
        end
        i_s_axis_tvalid <= 1'b0;
        drain_verdicts();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
